[rtl/ssc_pkg.sv]
// Shared constants for the sphere-sphere contact pipeline.
`default_nettype none
package ssc_pkg;
  // Fraction bits of the unit normal and width of its port
  localparam int NORM_SHIFT = 30;
  localparam int NORM_W     = 32;
endpackage
`default_nettype wire

[rtl/sphere_sphere_contact_top.sv]
// Throughput: one request per cycle unless the output is stalled. The 33-stage root
// and 31-stage normal divider each resolve one bit per stage, and these two set the
// depth.
// The whole pipeline advances together and holds while a finished result is stalled.
// Reset (rst, synchronous) clears every valid bit; data registers are not reset.
`default_nettype none
module sphere_sphere_contact_top #(
  parameter int COORD_WIDTH = 32
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   req_valid,
  output logic                                  req_stall,
  input  wire  signed [COORD_WIDTH-1:0]         first_center_x,
  input  wire  signed [COORD_WIDTH-1:0]         first_center_y,
  input  wire  signed [COORD_WIDTH-1:0]         first_center_z,
  input  wire         [COORD_WIDTH-2:0]         first_radius,
  input  wire  signed [COORD_WIDTH-1:0]         second_center_x,
  input  wire  signed [COORD_WIDTH-1:0]         second_center_y,
  input  wire  signed [COORD_WIDTH-1:0]         second_center_z,
  input  wire         [COORD_WIDTH-2:0]         second_radius,
  output logic                                  rsp_valid,
  input  wire                                   rsp_stall,
  output logic                                  hit,
  output logic signed [ssc_pkg::NORM_W-1:0]     normal_x,
  output logic signed [ssc_pkg::NORM_W-1:0]     normal_y,
  output logic signed [ssc_pkg::NORM_W-1:0]     normal_z,
  output logic signed [COORD_WIDTH-1:0]         contact_x,
  output logic signed [COORD_WIDTH-1:0]         contact_y,
  output logic signed [COORD_WIDTH-1:0]         contact_z,
  output logic        [COORD_WIDTH-1:0]         penetration
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;             // signed difference
  localparam int SW   = 2 * CW;             // one square
  localparam int SSW  = 2 * CW + 2;         // sum of three squares
  localparam int RW   = CW + 1;             // root
  localparam int NS   = ssc_pkg::NORM_SHIFT;
  localparam int QW   = NS + 1;             // quotient magnitude
  localparam int DVW  = CW + NS;            // divider remainder
  localparam int CMPW = RW + NS;            // shifted divisor
  localparam int NW   = ssc_pkg::NORM_W;

  typedef struct packed {
    logic [2:0]                neg;
    logic [2:0][CW-1:0]        mag;
    logic [2:0][CW-1:0]        con;
    logic [CW-1:0]             rsum;
  } geo_t;

  typedef struct packed {
    logic                      hit;
    logic [2:0]                neg;
    logic [2:0][CW-1:0]        con;
    logic [CW-1:0]             pen;
    logic [RW-1:0]             len;
  } dcar_t;

  logic adv;
  assign adv       = !rsp_valid || !rsp_stall;
  assign req_stall = !adv;

  // Stage A: differences, magnitudes, contact point, radius sum
  logic        v_a;
  geo_t        ga;
  logic signed [DW-1:0]   d_c  [3];
  logic signed [CW+1:0]   p_c  [3];
  logic signed [CW-1:0]   c0_c [3];
  logic signed [CW-1:0]   c1_c [3];
  logic [2:0][CW-1:0]     mag_c;
  logic [2:0][CW-1:0]     con_c;

  assign c0_c[0] = first_center_x;
  assign c0_c[1] = first_center_y;
  assign c0_c[2] = first_center_z;
  assign c1_c[0] = second_center_x;
  assign c1_c[1] = second_center_y;
  assign c1_c[2] = second_center_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i] = DW'(c0_c[i]) - DW'(c1_c[i]);
      mag_c[i] = d_c[i][DW-1] ? CW'(-d_c[i]) : CW'(d_c[i]);
      p_c[i] = (CW+2)'(c0_c[i]) + (CW+2)'(d_c[i] >>> 1);
      // clamp to the coordinate range
      if (p_c[i][CW+1:CW-1] != 3'b000 && p_c[i][CW+1:CW-1] != 3'b111) begin
        con_c[i] = p_c[i][CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        con_c[i] = p_c[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (adv) begin
      v_a <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ga.neg[i] <= d_c[i][DW-1];
      end
      ga.mag  <= mag_c;
      ga.con  <= con_c;
      ga.rsum <= CW'(first_radius) + CW'(second_radius);
    end
  end

  // Stage B: squares
  logic           v_b;
  geo_t           gb;
  logic [SW-1:0]  sq_b [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (adv) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gb <= ga;
      for (int i = 0; i < 3; i++) begin
        sq_b[i] <= SW'(ga.mag[i]) * SW'(ga.mag[i]);
      end
    end
  end

  // Root pipeline: index 0 is the squared length, one root bit per stage
  logic            sv   [RW+1];
  geo_t            sg   [RW+1];
  logic [SSW-1:0]  srem [RW+1];
  logic [RW-1:0]   sroot[RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sg[0]    <= gb;
      srem[0]  <= SSW'(sq_b[0]) + SSW'(sq_b[1]) + SSW'(sq_b[2]);
      sroot[0] <= '0;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_root
    localparam int B = RW - 1 - k;
    logic [SSW:0] trial;
    logic [SSW:0] rem_x;
    assign trial = ({{(SSW+1-RW){1'b0}}, sroot[k]} << (B + 1)) | ((SSW+1)'(1) << (2 * B));
    assign rem_x = {1'b0, srem[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    // Keep the bit when its square still fits under the remainder
    always_ff @(posedge clk) begin
      if (adv) begin
        sg[k+1] <= sg[k];
        if (rem_x >= trial) begin
          srem[k+1]  <= SSW'(rem_x - trial);
          sroot[k+1] <= sroot[k] | (RW'(1) << B);
        end else begin
          srem[k+1]  <= srem[k];
          sroot[k+1] <= sroot[k];
        end
      end
    end
  end

  // Hit decision and divider set-up
  logic            dv   [QW+1];
  dcar_t           dc   [QW+1];
  logic [DVW-1:0]  drem [QW+1][3];
  logic [QW-1:0]   dq   [QW+1][3];
  logic            hit_c;

  assign hit_c = (sroot[RW] != '0) && (sroot[RW] < {1'b0, sg[RW].rsum});

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= sv[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dc[0].hit <= hit_c;
      dc[0].neg <= sg[RW].neg;
      dc[0].con <= sg[RW].con;
      dc[0].pen <= sg[RW].rsum - sroot[RW][CW-1:0];
      dc[0].len <= sroot[RW];
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= {sg[RW].mag[i], {NS{1'b0}}};
        dq[0][i]   <= '0;
      end
    end
  end

  // Normal divider: one quotient bit per stage for all three lanes
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = NS - j;
    logic [CMPW-1:0] dvs;
    assign dvs = {{NS{1'b0}}, dc[j].len} << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (adv) begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dc[j+1] <= dc[j];
        for (int i = 0; i < 3; i++) begin
          if (CMPW'(drem[j][i]) >= dvs) begin
            drem[j+1][i] <= DVW'(CMPW'(drem[j][i]) - dvs);
            dq[j+1][i]   <= dq[j][i] | (QW'(1) << B);
          end else begin
            drem[j+1][i] <= drem[j][i];
            dq[j+1][i]   <= dq[j][i];
          end
        end
      end
    end
  end

  // Output register: apply signs, drop fields on a miss
  logic [NW-1:0] nrm_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_c[i] = dc[QW].neg[i] ? -NW'(dq[QW][i]) : NW'(dq[QW][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit         <= dc[QW].hit;
      normal_x    <= dc[QW].hit ? nrm_c[0] : '0;
      normal_y    <= dc[QW].hit ? nrm_c[1] : '0;
      normal_z    <= dc[QW].hit ? nrm_c[2] : '0;
      contact_x   <= dc[QW].hit ? dc[QW].con[0] : '0;
      contact_y   <= dc[QW].hit ? dc[QW].con[1] : '0;
      contact_z   <= dc[QW].hit ? dc[QW].con[2] : '0;
      penetration <= dc[QW].hit ? dc[QW].pen : '0;
    end
  end

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the sphere-sphere contact pipeline.
module tb_top;

  localparam int CW = 32;

  typedef struct {
    logic signed [CW-1:0] c0[3];
    logic signed [CW-1:0] c1[3];
    logic [CW-2:0] r0;
    logic [CW-2:0] r1;
  } pair_t;

  typedef struct {
    logic hit;
    logic [ssc_pkg::NORM_W-1:0] n[3];
    logic [CW-1:0] c[3];
    logic [CW-1:0] pen;
  } contact_t;

  typedef struct {
    pair_t p;
    bit fixed;
    contact_t want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  logic signed [CW-1:0] c0x = 0, c0y = 0, c0z = 0, c1x = 0, c1y = 0, c1z = 0;
  logic [CW-2:0] rad0 = 0, rad1 = 0;
  logic rsp_valid;
  logic rsp_stall = 0;
  logic hit;
  logic signed [ssc_pkg::NORM_W-1:0] normal_x, normal_y, normal_z;
  logic signed [CW-1:0] contact_x, contact_y, contact_z;
  logic [CW-1:0] penetration;

  contact_t contact_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_hits = 0;
  int n_checked = 0;
  bit calm = 0;

  sphere_sphere_contact_top #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .first_center_x(c0x), .first_center_y(c0y), .first_center_z(c0z),
    .first_radius(rad0),
    .second_center_x(c1x), .second_center_y(c1y), .second_center_z(c1z),
    .second_radius(rad1),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .hit(hit), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .contact_x(contact_x), .contact_y(contact_y), .contact_z(contact_z),
    .penetration(penetration)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Work out the contact result of one sphere pair
  function automatic contact_t sphere_contact(pair_t p);
    contact_t r;
    longint d[3];
    longint lim;
    longint pt;
    logic [127:0] sq;
    logic [127:0] quo;
    logic [63:0] m;
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] rsum;
    r.hit = 0;
    r.pen = 0;
    sq = 0;
    lim = longint'(1) <<< (CW - 1);
    for (int i = 0; i < 3; i++) begin
      r.n[i] = 0;
      r.c[i] = 0;
      d[i] = longint'(p.c0[i]) - longint'(p.c1[i]);
      m = d[i] < 0 ? -d[i] : d[i];
      sq = sq + 128'(m) * 128'(m);
    end
    root = 0;
    for (int b = 62; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= sq) root = trial;
    end
    rsum = 64'(p.r0) + 64'(p.r1);
    if (root == 0 || root >= rsum) return r;
    r.hit = 1;
    for (int i = 0; i < 3; i++) begin
      m = d[i] < 0 ? -d[i] : d[i];
      quo = (128'(m) << ssc_pkg::NORM_SHIFT) / 128'(root);
      r.n[i] = d[i] < 0 ? -quo[ssc_pkg::NORM_W-1:0] : quo[ssc_pkg::NORM_W-1:0];
      pt = longint'(p.c0[i]) + (d[i] >>> 1);
      if (pt > lim - 1) pt = lim - 1;
      if (pt < -lim) pt = -lim;
      r.c[i] = pt[CW-1:0];
    end
    r.pen = CW'(rsum - root);
    return r;
  endfunction

  function automatic contact_t no_contact();
    contact_t r;
    r.hit = 0;
    r.pen = 0;
    for (int i = 0; i < 3; i++) begin
      r.n[i] = 0;
      r.c[i] = 0;
    end
    return r;
  endfunction

  function automatic pair_t make_pair(longint ax, longint ay, longint az, longint ra,
                                      longint bx, longint by, longint bz, longint rb);
    pair_t p;
    p.c0[0] = CW'(ax); p.c0[1] = CW'(ay); p.c0[2] = CW'(az);
    p.c1[0] = CW'(bx); p.c1[1] = CW'(by); p.c1[2] = CW'(bz);
    p.r0 = (CW-1)'(ra);
    p.r1 = (CW-1)'(rb);
    return p;
  endfunction

  // Random gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int k;
    k = $urandom_range(99);
    if (calm) return 0;
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offer one request, hold it until taken, then record what must come back
  task automatic send_pair(pair_t p, bit fixed, contact_t want);
    int gap;
    req_valid <= 1;
    c0x <= p.c0[0]; c0y <= p.c0[1]; c0z <= p.c0[2]; rad0 <= p.r0;
    c1x <= p.c1[0]; c1y <= p.c1[1]; c1z <= p.c1[2]; rad1 <= p.r1;
    do @(posedge clk); while (req_stall);
    contact_q.push_back(fixed ? want : sphere_contact(p));
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random pair: either fully random or a near pair likely to overlap
  function automatic pair_t random_pair();
    pair_t p;
    logic signed [CW-1:0] delta;
    int sh;
    for (int i = 0; i < 3; i++) p.c0[i] = $urandom;
    if ($urandom_range(99) < 20) begin
      for (int i = 0; i < 3; i++) p.c1[i] = $urandom;
      p.r0 = (CW-1)'($urandom);
      p.r1 = (CW-1)'($urandom);
      return p;
    end
    sh = $urandom_range(31, 2);
    for (int i = 0; i < 3; i++) begin
      delta = $urandom;
      p.c1[i] = p.c0[i] - (delta >>> sh);
    end
    p.r0 = (CW-1)'(CW'($urandom) >> (sh + $urandom_range(1, 0)));
    p.r1 = (CW-1)'(CW'($urandom) >> (sh + $urandom_range(1, 0)));
    return p;
  endfunction

  // Receiver back-pressure in runs, with calm stretches
  int stall_run = 0;
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (calm || $urandom_range(99) < 55) begin
      rsp_stall <= 0;
    end else begin
      rsp_stall <= ~rsp_stall;
      stall_run <= ($urandom_range(99) < 90) ? $urandom_range(3) : $urandom_range(50, 10);
    end
  end

  task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each result with the oldest outstanding request
  always @(posedge clk) begin
    contact_t w;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (contact_q.size() == 0) begin
        $display("%0t mismatch: unexpected result, expected none actual hit=%b", $time, hit);
        errors++;
      end else begin
        w = contact_q.pop_front();
        n_checked++;
        if (w.hit) n_hits++;
        check_field("hit", CW'(w.hit), CW'(hit));
        check_field("normal_x", w.n[0], normal_x);
        check_field("normal_y", w.n[1], normal_y);
        check_field("normal_z", w.n[2], normal_z);
        check_field("contact_x", w.c[0], contact_x);
        check_field("contact_y", w.c[1], contact_y);
        check_field("contact_z", w.c[2], contact_z);
        check_field("penetration", w.pen, penetration);
      end
    end
  end

  row_t rows[$];
  contact_t unit_x;

  initial begin
    longint one;
    longint mx;
    longint mn;
    longint rmax;
    one = 65536;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    rmax = 64'd2147483647;
    unit_x = no_contact();
    unit_x.hit = 1;
    unit_x.n[0] = 32'h4000_0000;
    unit_x.c[0] = 32'd98304;
    unit_x.pen = 32'd65536;

    // Directed: coincident, simple hit, touching, extremes, saturation, rounding
    rows.push_back('{make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, no_contact()});
    rows.push_back('{make_pair(one, 0, 0, one, 0, 0, 0, one), 1, unit_x});
    rows.push_back('{make_pair(2*one, 0, 0, one, 0, 0, 0, one), 1, no_contact()});
    rows.push_back('{make_pair(5, -7, 9, rmax, 5, -7, 9, rmax), 1, no_contact()});
    rows.push_back('{make_pair(mx, mx, mx, rmax, mn, mn, mn, rmax), 1, no_contact()});
    rows.push_back('{make_pair(mn, mn, mn, rmax, mx, mx, mx, rmax), 1, no_contact()});
    rows.push_back('{make_pair(mx, 0, 0, rmax, mx - 65535, 0, 0, 0), 0, no_contact()});
    rows.push_back('{make_pair(mn, 0, 0, rmax, mn + one, 0, 0, 0), 0, no_contact()});
    rows.push_back('{make_pair(mx, mx, mx, rmax, mn, mx, mx, rmax), 0, no_contact()});
    rows.push_back('{make_pair(mn, mn, mn, 0, mx, mn, mn, rmax), 0, no_contact()});
    rows.push_back('{make_pair(0, 0, 0, 10, 3, 0, 0, 0), 0, no_contact()});
    rows.push_back('{make_pair(-3, 5, -1, 4, 0, 0, 0, 4), 0, no_contact()});
    rows.push_back('{make_pair(one, one, one, one, 0, 0, 0, one), 0, no_contact()});
    rows.push_back('{make_pair(1, 0, 0, 1, 0, 0, 0, 1), 0, no_contact()});
    rows.push_back('{make_pair(0, -one, 0, 0, 0, 0, 0, 2*one), 0, no_contact()});
    rows.push_back('{make_pair(0, 0, 1000, 0, 0, 0, -1000, 2001), 0, no_contact()});
    rows.push_back('{make_pair(0, 0, 1000, 0, 0, 0, -1000, 2000), 0, no_contact()});

    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) send_pair(rows[i].p, rows[i].fixed, rows[i].want);

    for (int k = 0; k < 1300; k++) begin
      calm = (k >= 400 && k < 550);
      // Let the pipeline drain once with the sender paused
      if (k == 700) begin
        req_valid <= 0;
        wait (contact_q.size() == 0);
        @(posedge clk);
      end
      send_pair(random_pair(), 0, no_contact());
    end
    req_valid <= 0;
    calm = 0;

    wait (contact_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("Sent %0d sphere pairs, checked %0d results, %0d of them contacts.",
             n_sent, n_checked, n_hits);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung pipeline
  initial begin
    #8000000;
    $display("Timed out with %0d results outstanding.", contact_q.size());
    $display("FAIL");
    $finish;
  end
endmodule

[filelist.f]
rtl/ssc_pkg.sv
rtl/sphere_sphere_contact_top.sv
bench/tb_top.sv
